### sv/keyed_fifo_with_expiry_core_defines.svh
// Assertion macros used by the keyed FIFO top level.
`ifndef KEYED_FIFO_WITH_EXPIRY_CORE_DEFINES_SVH
`define KEYED_FIFO_WITH_EXPIRY_CORE_DEFINES_SVH
// Implication checked on every clock edge outside reset.
`define KFE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
// Next-cycle implication checked outside reset.
`define KFE_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`endif

### sv/kfe_pkg.sv
// Package with the shared constants and types of the keyed FIFO block.
package kfe_pkg;
    localparam int Depth     = 32;
    localparam int SlotW     = $clog2(Depth);
    localparam int CountW    = $clog2(Depth + 1);
    localparam int MaxResults = 32;
    localparam int TotalW    = 48;
    localparam logic [TotalW-1:0] TotalMax = {TotalW{1'b1}};

    typedef enum logic [1:0] {
        FUNC_INSERT = 2'd0,
        FUNC_ERASE  = 2'd1,
        FUNC_POP    = 2'd2,
        FUNC_EXPIRE = 2'd3
    } t_func;

    typedef enum logic [1:0] {
        ST_DONE    = 2'd0,
        ST_NONE    = 2'd1,
        ST_FULL    = 2'd2,
        ST_INVALID = 2'd3
    } t_status;

    // One scan step result passed from the compare unit to the sequencer.
    typedef struct packed {
        logic             hit;
        logic             better;
    } t_cmp;
endpackage

### sv/kfe_cmp.sv
// Shared compare unit: id match and expiry-due test for one slot per cycle.
module kfe_cmp
    import kfe_pkg::*;
(
    input  logic        i_valid,
    input  logic [15:0] i_slot_id,
    input  logic [15:0] i_key,
    input  logic        i_has_exp,
    input  logic [31:0] i_exp,
    input  logic [31:0] i_now,
    input  logic        i_have_best,
    input  logic [31:0] i_best_exp,
    input  logic        i_mode_exp,
    output t_cmp        o_res
);
    logic due;
    always_comb begin
        due = i_valid && i_has_exp && (i_exp <= i_now);
        if (i_mode_exp) begin
            o_res.hit    = due;
            o_res.better = due && (!i_have_best || (i_exp < i_best_exp));
        end else begin
            o_res.hit    = i_valid && (i_slot_id == i_key);
            o_res.better = 1'b0;
        end
    end
endmodule

### sv/keyed_fifo_with_expiry_core.sv
// Top level of the keyed FIFO with expiry: sequencer, slot store and totals.
//
// Each transfer on start runs one operation. An insert or erase with id zero and a
// pop of an empty table are answered at once: the result is strobed in the cycle
// after the transfer and busy never rises. Otherwise busy stays high until the last
// result has been strobed on o_strobe. Insert and erase walk all slots through one
// shared compare unit, one slot per cycle. An erase that finds the id removes it;
// an erase that misses answers when the walk ends. An insert first removes a held
// entry with the same id, then writes into the lowest free slot. Pop oldest removes
// the oldest entry without a walk. Expire walks the age list once per removal
// through the same unit, plus a closing walk that finds nothing more due. Each
// removal result is held until the following walk shows whether it is the final
// one, so it is strobed when that walk ends; at most 32 results are issued, and
// with nothing due one result with status "nothing due" comes out. Results are
// single-cycle strobes that the receiver cannot stall. The per-slot payload is
// held in arrays read at one address a cycle; only the valid bits are reset, so
// there is no clearing pass.
`include "keyed_fifo_with_expiry_core_defines.svh"
module keyed_fifo_with_expiry_core
    import kfe_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  i_func,
    input  logic [15:0] i_packet_id,
    input  logic [28:0] i_byte_size,
    input  logic        i_has_expiry,
    input  logic [31:0] i_expire_time,
    input  logic [31:0] i_current_time,
    output logic        o_strobe,
    output logic        o_removed_valid,
    output logic [15:0] o_removed_id,
    output logic [1:0]  o_status,
    output logic [5:0]  o_entry_count_out,
    output logic [47:0] o_byte_total_out,
    output logic        o_last
);
    typedef enum logic [2:0] {
        S_IDLE, S_FIND, S_REMOVE, S_INSERT, S_SCAN, S_EMIT
    } t_state;

    // Slot store; only the valid bits are reset.
    logic [Depth-1:0] r_valid;
    logic [15:0]      m_id    [Depth];
    logic [28:0]      m_bytes [Depth];
    logic             m_hasx  [Depth];
    logic [31:0]      m_exp   [Depth];
    logic [SlotW-1:0] m_newer [Depth];
    logic [SlotW-1:0] m_older [Depth];

    t_state            r_state;
    t_func             r_func;
    logic [15:0]       r_key;
    logic [28:0]       r_bytes;
    logic              r_hasx;
    logic [31:0]       r_xtime;
    logic [31:0]       r_now;
    logic [SlotW-1:0]  r_newest, r_oldest, r_cur, r_best, r_found;
    logic [CountW-1:0] r_count, r_idx;
    logic [TotalW-1:0] r_total;
    logic              r_have_best, r_have_found;
    logic [31:0]       r_best_exp;
    logic [5:0]        r_nres;
    logic [SlotW-1:0]  r_free;
    logic              r_have_free;

    t_cmp c;
    kfe_cmp u_cmp (
        .i_valid(r_valid[r_cur]), .i_slot_id(m_id[r_cur]), .i_key(r_key),
        .i_has_exp(m_hasx[r_cur]), .i_exp(m_exp[r_cur]), .i_now(r_now),
        .i_have_best(r_have_best), .i_best_exp(r_best_exp),
        .i_mode_exp(r_func == FUNC_EXPIRE), .o_res(c)
    );

    assign busy = (r_state != S_IDLE);

    // Removal of slot s from the age list and the totals.
    logic [SlotW-1:0]  rm_s, rm_old, rm_new;
    logic [TotalW-1:0] rm_total;
    always_comb begin
        rm_s   = (r_func == FUNC_EXPIRE) ? r_best : r_found;
        rm_old = m_older[rm_s];
        rm_new = m_newer[rm_s];
        if (r_total >= {{(TotalW-29){1'b0}}, m_bytes[rm_s]})
            rm_total = r_total - {{(TotalW-29){1'b0}}, m_bytes[rm_s]};
        else
            rm_total = '0;
    end

    logic [TotalW:0] add_total;
    assign add_total = {1'b0, r_total} + {{(TotalW-28){1'b0}}, r_bytes};

    always_ff @(posedge i_clk) begin
        o_strobe <= 1'b0;
        o_last   <= 1'b0;
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_valid  <= '0;
            r_newest <= '0;
            r_oldest <= '0;
            r_count  <= '0;
            r_total  <= '0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_func  <= t_func'(i_func);
                        r_key   <= i_packet_id;
                        r_bytes <= i_byte_size;
                        r_hasx  <= i_has_expiry;
                        r_xtime <= i_expire_time;
                        r_now   <= i_current_time;
                        r_nres  <= '0;
                        r_cur   <= '0;
                        r_idx   <= '0;
                        r_have_found <= 1'b0;
                        r_have_best  <= 1'b0;
                        r_have_free  <= 1'b0;
                        unique case (t_func'(i_func)) inside
                            FUNC_INSERT, FUNC_ERASE: begin
                                if (i_packet_id == '0) begin
                                    o_strobe <= 1'b1; o_last <= 1'b1;
                                    o_removed_valid <= 1'b0; o_removed_id <= '0;
                                    o_status <= ST_INVALID;
                                    o_entry_count_out <= 6'(r_count);
                                    o_byte_total_out <= r_total;
                                end else begin
                                    r_state <= S_FIND;
                                end
                            end
                            FUNC_POP: begin
                                if (r_count == '0) begin
                                    o_strobe <= 1'b1; o_last <= 1'b1;
                                    o_removed_valid <= 1'b0; o_removed_id <= '0;
                                    o_status <= ST_NONE;
                                    o_entry_count_out <= 6'(r_count);
                                    o_byte_total_out <= r_total;
                                end else begin
                                    r_found <= r_oldest;
                                    r_have_found <= 1'b1;
                                    r_state <= S_REMOVE;
                                end
                            end
                            default: begin
                                r_cur <= r_oldest;
                                r_state <= S_SCAN;
                            end
                        endcase
                    end
                end
                S_FIND: begin
                    // Linear id search, one slot a cycle; also finds a free slot.
                    if (c.hit && !r_have_found) begin
                        r_found <= r_cur;
                        r_have_found <= 1'b1;
                    end
                    if (!r_valid[r_cur] && !r_have_free) begin
                        r_free <= r_cur;
                        r_have_free <= 1'b1;
                    end
                    if (r_cur == SlotW'(Depth - 1)) begin
                        if (r_have_found || c.hit) r_state <= S_REMOVE;
                        else if (r_func == FUNC_INSERT) r_state <= S_INSERT;
                        else begin
                            r_state <= S_IDLE;
                            o_strobe <= 1'b1; o_last <= 1'b1;
                            o_removed_valid <= 1'b0; o_removed_id <= '0;
                            o_status <= ST_NONE;
                            o_entry_count_out <= 6'(r_count);
                            o_byte_total_out <= r_total;
                        end
                    end else begin
                        r_cur <= r_cur + 1'b1;
                    end
                end
                S_REMOVE: begin
                    // Removing the only entry returns both ends of the list to slot zero.
                    if (r_count == CountW'(1)) begin
                        r_oldest <= '0;
                        r_newest <= '0;
                    end else begin
                        if (rm_s == r_oldest) r_oldest <= rm_new;
                        if (rm_s == r_newest) r_newest <= rm_old;
                    end
                    if (rm_s != r_oldest) m_newer[rm_old] <= rm_new;
                    if (rm_s != r_newest) m_older[rm_new] <= rm_old;
                    r_valid[rm_s] <= 1'b0;
                    r_count <= r_count - 1'b1;
                    r_total <= rm_total;
                    if (r_func == FUNC_INSERT) begin
                        // The freed slot is a valid choice when it is the lowest one.
                        if (!r_have_free || rm_s < r_free) r_free <= rm_s;
                        r_have_free <= 1'b1;
                        r_state <= S_INSERT;
                    end else begin
                        o_removed_valid <= 1'b1;
                        o_removed_id <= m_id[rm_s];
                        o_status <= ST_DONE;
                        o_entry_count_out <= 6'(r_count - 1'b1);
                        o_byte_total_out <= rm_total;
                        if (r_func == FUNC_EXPIRE) begin
                            r_nres <= r_nres + 1'b1;
                            if (r_nres == 6'(MaxResults - 1)) begin
                                o_strobe <= 1'b1;
                                o_last <= 1'b1;
                                r_state <= S_IDLE;
                            end else begin
                                // The result waits on the outputs until the next walk
                                // shows whether another entry is due.
                                r_state <= S_SCAN;
                                r_cur <= (r_count == CountW'(1)) ? '0 :
                                         ((rm_s == r_oldest) ? rm_new : r_oldest);
                                r_idx <= '0;
                                r_have_best <= 1'b0;
                            end
                        end else begin
                            o_strobe <= 1'b1;
                            o_last <= 1'b1;
                            r_state <= S_IDLE;
                        end
                    end
                end
                S_INSERT: begin
                    o_strobe <= 1'b1; o_last <= 1'b1;
                    o_removed_valid <= 1'b0; o_removed_id <= '0;
                    o_entry_count_out <= 6'(r_count);
                    o_byte_total_out <= r_total;
                    r_state <= S_IDLE;
                    if (r_count >= CountW'(Depth) || !r_have_free) begin
                        o_status <= ST_FULL;
                    end else begin
                        o_status <= ST_DONE;
                        m_id[r_free]    <= r_key;
                        m_bytes[r_free] <= r_bytes;
                        m_hasx[r_free]  <= r_hasx;
                        m_exp[r_free]   <= r_xtime;
                        if (r_count == '0) r_oldest <= r_free;
                        else begin
                            m_older[r_free]   <= r_newest;
                            m_newer[r_newest] <= r_free;
                        end
                        r_newest <= r_free;
                        r_valid[r_free] <= 1'b1;
                        r_count <= r_count + 1'b1;
                        o_entry_count_out <= 6'(r_count + 1'b1);
                        if (add_total[TotalW]) begin
                            r_total <= TotalMax;
                            o_byte_total_out <= TotalMax;
                        end else begin
                            r_total <= add_total[TotalW-1:0];
                            o_byte_total_out <= add_total[TotalW-1:0];
                        end
                    end
                end
                S_SCAN: begin
                    // Oldest-first walk; strict compare keeps the oldest of equals.
                    if (r_idx < r_count) begin
                        if (c.better) begin
                            r_best <= r_cur;
                            r_best_exp <= m_exp[r_cur];
                            r_have_best <= 1'b1;
                        end
                        r_cur <= m_newer[r_cur];
                        r_idx <= r_idx + 1'b1;
                    end else begin
                        r_state <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (r_have_best) begin
                        r_state <= S_REMOVE;
                        // A held removal is released now, knowing that more follow.
                        if (r_nres != '0) o_strobe <= 1'b1;
                    end else begin
                        r_state <= S_IDLE;
                        o_strobe <= 1'b1;
                        o_last <= 1'b1;
                        // With nothing removed the single result says nothing was due;
                        // otherwise the held removal goes out as the final one.
                        if (r_nres == '0) begin
                            o_removed_valid <= 1'b0; o_removed_id <= '0;
                            o_status <= ST_NONE;
                            o_entry_count_out <= 6'(r_count);
                            o_byte_total_out <= r_total;
                        end
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    `KFE_ASSERT_IMP(a_last_has_strobe, i_clk, i_rst_n, o_last, o_strobe)
    `KFE_ASSERT_IMP(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= CountW'(Depth))
    `KFE_ASSERT_NEXT(a_start_busy, i_clk, i_rst_n, start && !busy && !o_strobe, busy || o_strobe)
endmodule
